>>> design/bytecode_container_validator_macros.svh
// assertion macros for the container validator checker
`ifndef BYTECODE_CONTAINER_VALIDATOR_MACROS_SVH
`define BYTECODE_CONTAINER_VALIDATOR_MACROS_SVH

// implication checked on every clock edge outside reset
`define BCV_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcv check failed");

// next-cycle implication checked on every clock edge outside reset
`define BCV_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bcv check failed");

`endif

>>> design/bcv_pkg.sv
// ----------------------------------------------------------------------------
// bcv_pkg
// types and constants shared by the container validator
// ----------------------------------------------------------------------------
package bcv_pkg;

  localparam int LEN_BITS  = 32;
  localparam int CNT_W     = LEN_BITS + 1;
  localparam int NUM_SEC   = 6;
  localparam int SEC_IDX_W = 3;
  localparam int HDR_BYTES = 32;
  localparam int ENT_BYTES = 24;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(1) << LEN_BITS;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FORMAT  = 2'd1,
    ST_CRC     = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef logic [31:0] tag_t;

  localparam tag_t TAG_CODE = 32'h45444F43;
  localparam tag_t TAG_KCON = 32'h4E4F434B;
  localparam tag_t TAG_STRS = 32'h53525453;
  localparam tag_t TAG_SYMS = 32'h534D5953;
  localparam tag_t TAG_FUNC = 32'h434E5546;
  localparam tag_t TAG_DBG  = 32'h00474244;

  localparam logic [SEC_IDX_W-1:0] SEC_CODE = 3'd0;
  localparam logic [SEC_IDX_W-1:0] SEC_FUNC = 3'd4;
  localparam logic [SEC_IDX_W-1:0] SEC_LAST = 3'd5;

  typedef struct packed {
    logic [31:0] off;
    logic [31:0] len;
  } sec_entry_t;

  // finished table entry handed to the section store
  typedef struct packed {
    logic                 wr;
    logic [SEC_IDX_W-1:0] idx;
    sec_entry_t           data;
  } sec_wr_t;

  // end-of-image summary handed to the result emitter
  typedef struct packed {
    logic        start;
    status_t     status;
    logic [15:0] vmaj;
    logic [15:0] vmin;
    logic [15:0] flags;
    logic [NUM_SEC-1:0] valid;
  } fin_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] p);
    logic [7:0] m;
    case (p)
      2'd0:    m = 8'h56;
      2'd1:    m = 8'h54;
      2'd2:    m = 8'h42;
      default: m = 8'h43;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? (CRC_POLY ^ (x >> 1)) : (x >> 1);
    end
    return x;
  endfunction

endpackage

>>> design/bcv_emit.sv
// ----------------------------------------------------------------------------
// bcv_emit
// section store memory and result emitter, six results per image
// ----------------------------------------------------------------------------
module bcv_emit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bcv_pkg::sec_wr_t          sec_wr,
  input  bcv_pkg::fin_t             fin,
  output logic                      busy,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_status,
  output logic [2:0]                out_section_id,
  output logic                      out_present,
  output logic [31:0]               out_section_offset,
  output logic [31:0]               out_section_length,
  output logic [15:0]               out_version_major,
  output logic [15:0]               out_version_minor,
  output logic [15:0]               out_header_flags,
  output logic                      out_last_result
);
  import bcv_pkg::*;

  sec_entry_t sec_mem [NUM_SEC];
  sec_entry_t rd_data_r;

  logic                 act_r, act_nxt;
  logic [SEC_IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic                 pend_r, pend_nxt;
  logic [SEC_IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  status_t              st_r;
  logic [15:0]          vmaj_r, vmin_r, flg_r;
  logic [NUM_SEC-1:0]   vld_r;
  logic                 ov_r, ov_nxt;
  logic                 rd_en;
  logic                 take;
  logic                 pend_mv;

  always_ff @(posedge clk) begin
    if (sec_wr.wr) begin
      sec_mem[sec_wr.idx] <= sec_wr.data;
    end
    if (rd_en) begin
      rd_data_r <= sec_mem[rd_idx_r];
    end
  end

  // read data moves to the output register whenever that one frees up
  assign take    = ov_r && !out_stall;
  assign pend_mv = pend_r && (!ov_r || take);
  assign rd_en   = act_r && (!pend_r || pend_mv);

  always_comb begin
    act_nxt      = act_r;
    rd_idx_nxt   = rd_idx_r;
    pend_nxt     = pend_r;
    pend_idx_nxt = pend_idx_r;
    ov_nxt       = ov_r;
    if (take) begin
      ov_nxt = 1'b0;
    end
    if (pend_mv) begin
      ov_nxt   = 1'b1;
      pend_nxt = 1'b0;
    end
    if (rd_en) begin
      pend_nxt     = 1'b1;
      pend_idx_nxt = rd_idx_r;
      if (rd_idx_r == SEC_LAST) begin
        act_nxt = 1'b0;
      end else begin
        rd_idx_nxt = rd_idx_r + 3'd1;
      end
    end
    if (fin.start) begin
      act_nxt    = 1'b1;
      rd_idx_nxt = '0;
    end
  end

  logic [SEC_IDX_W-1:0] o_idx_r;
  sec_entry_t           o_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      pend_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      act_r  <= act_nxt;
      pend_r <= pend_nxt;
      ov_r   <= ov_nxt;
    end
    rd_idx_r   <= rd_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    if (pend_mv) begin
      o_idx_r  <= pend_idx_r;
      o_data_r <= rd_data_r;
    end
    if (fin.start) begin
      st_r   <= fin.status;
      vmaj_r <= fin.vmaj;
      vmin_r <= fin.vmin;
      flg_r  <= fin.flags;
      vld_r  <= fin.valid;
    end
  end

  logic ok;
  assign ok = (st_r == ST_OK);

  assign busy               = act_r || pend_r || ov_r;
  assign out_valid          = ov_r;
  assign out_status         = st_r;
  assign out_section_id     = o_idx_r;
  assign out_present        = ok && vld_r[o_idx_r];
  assign out_section_offset = (ok && vld_r[o_idx_r]) ? o_data_r.off : 32'd0;
  assign out_section_length = (ok && vld_r[o_idx_r]) ? o_data_r.len : 32'd0;
  assign out_version_major  = vmaj_r;
  assign out_version_minor  = vmin_r;
  assign out_header_flags   = flg_r;
  assign out_last_result    = (o_idx_r == SEC_LAST);

endmodule

>>> design/bytecode_container_validator.sv
// one byte per cycle while in_stall is low; the header, table and crc are updated
// in the cycle a byte is accepted. the last byte sets fin_go, which starts the six
// results; they leave one per cycle while out_stall is low, from a registered
// section memory read. the input stalls while they drain.
// synchronous active-low reset returns all parsing state to an empty image.
// ----------------------------------------------------------------------------
// bytecode_container_validator
// streaming container header, table and crc check
// ----------------------------------------------------------------------------
module bytecode_container_validator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [2:0]  out_section_id,
  output logic        out_present,
  output logic [31:0] out_section_offset,
  output logic [31:0] out_section_length,
  output logic [15:0] out_version_major,
  output logic [15:0] out_version_minor,
  output logic [15:0] out_header_flags,
  output logic        out_last_result
);
  import bcv_pkg::*;

  logic [CNT_W-1:0]   cnt_r;
  logic               mg_r;
  logic [47:0]        vf_r;
  logic [31:0]        hs_r;
  logic [63:0]        is_r;
  logic [31:0]        sc_r;
  logic [31:0]        ec_r;
  logic [31:0]        crc_r;
  logic [31:0]        ei_r;
  logic [4:0]         ep_r;
  logic [31:0]        tag_r;
  logic [63:0]        off_r, len_r;
  logic               bad_r;
  logic [NUM_SEC-1:0] sv_r;

  logic    acc, busy, fin_go;
  sec_wr_t sec_wr;
  fin_t    fin;

  assign in_stall = busy || fin_go;
  assign acc      = in_valid && !in_stall;

  logic [63:0] p;
  logic [7:0]  b;
  logic        in_tab, ent_done;
  logic [63:0] off_f, len_f;
  logic        fits;
  logic [2:0]  hit_idx;
  logic        hit;

  assign p        = 64'(cnt_r);
  assign b        = in_data_byte;
  assign in_tab   = (p >= 64'(HDR_BYTES)) && (ei_r < ec_r);
  assign ent_done = in_tab && (ep_r == 5'(ENT_BYTES - 1));
  assign off_f    = off_r;
  assign len_f    = {b, len_r[55:0]};
  assign fits     = (off_f <= is_r) && (len_f <= is_r) && (off_f <= is_r - len_f);

  always_comb begin
    hit     = 1'b1;
    hit_idx = 3'd0;
    case (tag_r)
      TAG_CODE: hit_idx = 3'd0;
      TAG_KCON: hit_idx = 3'd1;
      TAG_STRS: hit_idx = 3'd2;
      TAG_SYMS: hit_idx = 3'd3;
      TAG_FUNC: hit_idx = 3'd4;
      TAG_DBG:  hit_idx = 3'd5;
      default:  hit     = 1'b0;
    endcase
  end

  assign sec_wr.wr       = acc && ent_done && fits && hit;
  assign sec_wr.idx      = hit_idx;
  assign sec_wr.data.off = off_f[31:0];
  assign sec_wr.data.len = len_f[31:0];

  // final decision formed combinationally and registered by the emitter on fin.start
  status_t     st;
  logic [63:0] n;
  logic [31:0] hs_room;
  logic [36:0] ent_room;
  assign n        = p;
  assign hs_room  = hs_r - 32'(HDR_BYTES);
  // 24 bytes per entry
  assign ent_room = 37'({ec_r, 4'd0}) + 37'({ec_r, 3'd0});

  always_comb begin
    if (n < 64'(HDR_BYTES) || !mg_r || hs_r < 32'(HDR_BYTES)) st = ST_FORMAT;
    else if (cnt_r >= COUNT_LIMIT || is_r != n) st = ST_FORMAT;
    else if (64'(hs_r) > n) st = ST_FORMAT;
    else if ((crc_r ^ CRC_INIT) != sc_r) st = ST_CRC;
    else if ({5'd0, hs_room} < ent_room || bad_r) st = ST_FORMAT;
    else if (!sv_r[SEC_CODE] || !sv_r[SEC_FUNC]) st = ST_MISSING;
    else st = ST_OK;
  end

  assign fin.start  = fin_go;
  assign fin.status = st;
  assign fin.vmaj   = vf_r[15:0];
  assign fin.vmin   = vf_r[31:16];
  assign fin.flags  = vf_r[47:32];
  assign fin.valid  = sv_r;

  always_ff @(posedge clk) begin
    if (!rst_n || fin_go) begin
      fin_go <= 1'b0;
      cnt_r  <= '0;
      mg_r   <= 1'b1;
      vf_r   <= '0;
      hs_r   <= '0;
      is_r   <= '0;
      sc_r   <= '0;
      ec_r   <= '0;
      crc_r  <= CRC_INIT;
      ei_r   <= '0;
      ep_r   <= '0;
      tag_r  <= '0;
      off_r  <= '0;
      len_r  <= '0;
      bad_r  <= 1'b0;
      sv_r   <= '0;
    end else if (acc) begin
      if (p < 64'd4) begin
        if (b != magic_byte(p[1:0])) mg_r <= 1'b0;
      end else if (p < 64'd10) begin
        vf_r[8*3'(p[2:0] - 3'd4) +: 8] <= b;
      end else if (p >= 64'd12 && p < 64'd16) begin
        hs_r[8*p[1:0] +: 8] <= b;
      end else if (p >= 64'd16 && p < 64'd24) begin
        is_r[8*p[2:0] +: 8] <= b;
      end else if (p >= 64'd24 && p < 64'd28) begin
        sc_r[8*p[1:0] +: 8] <= b;
      end else if (p >= 64'd28 && p < 64'd32) begin
        ec_r[8*p[1:0] +: 8] <= b;
      end
      if (p >= 64'(HDR_BYTES) && p >= 64'(hs_r)) crc_r <= crc_byte(crc_r, b);
      if (in_tab) begin
        if (ep_r < 5'd4) tag_r[8*ep_r[1:0] +: 8] <= b;
        else if (ep_r >= 5'd8 && ep_r < 5'd16) off_r[8*ep_r[2:0] +: 8] <= b;
        else if (ep_r >= 5'd16) len_r[8*ep_r[2:0] +: 8] <= b;
        if (ent_done) begin
          if (!fits) bad_r <= 1'b1;
          else if (hit) sv_r[hit_idx] <= 1'b1;
          ei_r  <= ei_r + 32'd1;
          ep_r  <= '0;
          tag_r <= '0;
          off_r <= '0;
          len_r <= '0;
        end else begin
          ep_r <= ep_r + 5'd1;
        end
      end
      if (cnt_r < COUNT_LIMIT) cnt_r <= cnt_r + CNT_W'(1);
      fin_go <= in_last_byte;
    end
  end

  bcv_emit u_emit (
    .clk                (clk),
    .rst_n              (rst_n),
    .sec_wr             (sec_wr),
    .fin                (fin),
    .busy               (busy),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_section_id     (out_section_id),
    .out_present        (out_present),
    .out_section_offset (out_section_offset),
    .out_section_length (out_section_length),
    .out_version_major  (out_version_major),
    .out_version_minor  (out_version_minor),
    .out_header_flags   (out_header_flags),
    .out_last_result    (out_last_result)
  );

endmodule

>>> design/bcv_checker.sv
// ----------------------------------------------------------------------------
// bcv_checker
// port-level checks on the validator result channel
// ----------------------------------------------------------------------------
`include "bytecode_container_validator_macros.svh"

module bcv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [2:0]  out_section_id,
  input logic        out_present,
  input logic [31:0] out_section_offset,
  input logic        out_last_result
);
  import bcv_pkg::*;

  `BCV_ASSERT_IMP(a_id_range, out_valid, out_section_id <= SEC_LAST)
  `BCV_ASSERT_IMP(a_last_id, out_valid, out_last_result == (out_section_id == SEC_LAST))
  `BCV_ASSERT_IMP(a_present_ok, out_valid && out_present, out_status == ST_OK)
  `BCV_ASSERT_IMP(a_absent_zero, out_valid && !out_present, out_section_offset == 32'd0)
  `BCV_ASSERT_IMP(a_no_input, out_valid, in_stall)
endmodule

bind bytecode_container_validator bcv_checker u_bcv_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_status         (out_status),
  .out_section_id     (out_section_id),
  .out_present        (out_present),
  .out_section_offset (out_section_offset),
  .out_last_result    (out_last_result)
);
